### sv/controller_power_curve_map_core_defines.svh
// assertion macros for the controller power-curve map checker
// expects clk_i and rst_ni in the scope where a macro is used
`ifndef CONTROLLER_POWER_CURVE_MAP_CORE_DEFINES_SVH
`define CONTROLLER_POWER_CURVE_MAP_CORE_DEFINES_SVH

// condition or property that must hold at every clock edge out of reset
`define CPCM_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// consequent checked in the cycle after the antecedent
`define CPCM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

### sv/cpcm_pkg.sv
// shared widths, register indexes, stage numbers and constant functions
// for the controller power-curve map; no dependencies
package cpcm_pkg;

  // item and register widths
  localparam int FRAC_BITS  = 16;
  localparam int LIMIT_BITS = 24;
  localparam int CURVE_BITS = 12;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = LIMIT_BITS;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CURVE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HARD_MIN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HARD_MAX = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_USER_MIN = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_USER_MAX = 3'd4;

  // reset values
  localparam logic signed [LIMIT_BITS-1:0] LIMIT_MAX_RST = 24'sh7FFFFF;

  // curve limits, Q1.10
  localparam logic signed [CURVE_BITS-1:0] CURVE_MAX = 12'sd1024;
  localparam logic signed [CURVE_BITS-1:0] CURVE_MIN = -12'sd1024;

  // datapath formats
  localparam int LOG_BITS = 24;                       // fraction bits of log2
  localparam int Z_W      = 32;                       // Q1.31 squaring operand
  localparam int M_W      = $clog2(FRAC_BITS);        // top set bit position
  localparam int EXP_W    = $clog2(FRAC_BITS + 1);    // integer part of -log2
  localparam int NL_W     = EXP_W + LOG_BITS;         // -log2(x) in Q.24
  localparam int P_W      = 18;                       // exponent in Q.16
  localparam int P_FRAC   = 16;
  localparam int P_ONE    = 65536;
  localparam int N_W      = 30;                       // -p*log2(x) in Q.24
  localparam int K_W      = N_W - LOG_BITS;           // integer shift
  localparam int Y_FRAC   = 30;                       // y in Q1.30
  localparam int Y_W      = Y_FRAC + 1;
  localparam int C_W      = 32;                       // exp2 coefficients, Q0.32
  localparam int DIFF_W   = LIMIT_BITS + 1;
  localparam int PROD_W   = Y_W + 1 + DIFF_W;
  localparam int SUM_W    = PROD_W + 1;

  // pipeline stage numbers
  localparam int ST_NORM    = 0;
  localparam int ST_NL      = ST_NORM + LOG_BITS + 1;
  localparam int ST_N       = ST_NL + 1;
  localparam int ST_SHIFT   = ST_N + LOG_BITS + 1;
  localparam int ST_MUL     = ST_SHIFT + 1;
  localparam int ST_SUM     = ST_MUL + 1;
  localparam int ST_OUT     = ST_SUM + 1;
  localparam int NUM_STAGES = ST_OUT + 1;

  // derived configuration handed to the datapath
  typedef struct packed {
    logic [P_W-1:0]               p;
    logic signed [LIMIT_BITS-1:0] umin;
    logic signed [DIFF_W-1:0]     diff;
  } cfg_t;

  // integer square root, elaboration only
  function automatic logic [63:0] isqrt64(input logic [63:0] a_in);
    logic [63:0] a;
    logic [63:0] r;
    logic [63:0] b;
    a = a_in;
    r = '0;
    b = 64'h4000_0000_0000_0000;
    for (int j = 0; j < 32; j++) begin
      if (a >= r + b) begin
        a = a - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // 2^(-2^-idx) in Q0.32, built by repeated square roots from 0.5
  function automatic logic [C_W-1:0] exp_coef(input int idx);
    logic [63:0] cc;
    cc = 64'h8000_0000;
    for (int i = 1; i <= LOG_BITS; i++) begin
      if (i <= idx) begin
        cc = isqrt64(cc << 32);
      end
    end
    return cc[C_W-1:0];
  endfunction

endpackage

### sv/controller_power_curve_map_core.sv
// top level of the controller power-curve map
// uses cpcm_pkg, cpcm_cfg, cpcm_ctrl, cpcm_log2, cpcm_exp2, cpcm_map

// Maps a Q0.16 controller position x onto the user limits as
// user_min + x^p * (user_max - user_min), truncated toward zero, where the
// exponent p runs from 0.4 to 2.5 as curve_amount goes from -1 to +1. Every
// item passes through the 24 squaring stages of the log2 and the 24
// coefficient stages of the exp2, each holding one 32-bit multiplier; one
// item is accepted per clock while in_ready_o is high. When a result is not
// taken only the stages that are full behind it stall, so new items keep
// entering while bubbles remain. Configuration writes are taken every cycle
// and pass through the write registers and the registered derived values.
module controller_power_curve_map_core (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  logic [cpcm_pkg::FRAC_BITS-1:0]         controller_value_i,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic signed [cpcm_pkg::LIMIT_BITS-1:0] param_value_o,
  input  logic                                   cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  logic [cpcm_pkg::CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [cpcm_pkg::CFG_DATA_W-1:0]        cfg_data_i
);
  import cpcm_pkg::*;

  cfg_t                  cfg;
  logic [NUM_STAGES-1:0] en;
  logic [NL_W-1:0]       nl;
  logic                  nl_zero;
  logic [Y_W-1:0]        y;

  cpcm_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  cpcm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .en_o        (en)
  );

  cpcm_log2 u_log2 (
    .clk_i              (clk_i),
    .en_i               (en[ST_NL:0]),
    .controller_value_i (controller_value_i),
    .nl_o               (nl),
    .zero_o             (nl_zero)
  );

  cpcm_exp2 u_exp2 (
    .clk_i  (clk_i),
    .en_i   (en[ST_SHIFT:ST_N]),
    .nl_i   (nl),
    .zero_i (nl_zero),
    .p_i    (cfg.p),
    .y_o    (y)
  );

  cpcm_map u_map (
    .clk_i         (clk_i),
    .en_i          (en[ST_OUT:ST_MUL]),
    .y_i           (y),
    .cfg_i         (cfg),
    .param_value_o (param_value_o)
  );

endmodule

### sv/cpcm_cfg.sv
// configuration registers and the values derived from them (exponent,
// clamped user limits); uses cpcm_pkg
module cpcm_cfg (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [cpcm_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [cpcm_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  output cpcm_pkg::cfg_t                    cfg_o
);
  import cpcm_pkg::*;

  // floor(d / 5) as (d * DIV5_MUL) >> DIV5_SHIFT, exact for d < 2^22
  localparam int DIV5_SHIFT = 22;
  localparam int D_W        = 18;
  localparam logic [19:0] DIV5_MUL = 20'd838861;

  logic signed [CURVE_BITS-1:0] curve_q;
  logic signed [LIMIT_BITS-1:0] hard_min_q, hard_max_q, user_min_q, user_max_q;

  logic signed [CURVE_BITS-1:0] curve_cl;
  logic [CURVE_BITS-2:0]        mag;
  logic [D_W-1:0]               div_num;
  logic [D_W+19:0]              div_prod;
  logic [P_W-1:0]               p_pos, p_neg;
  logic signed [LIMIT_BITS-1:0] umin_c, umax_c;
  cfg_t                         cfg_d, cfg_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      curve_q    <= '0;
      hard_min_q <= '0;
      hard_max_q <= LIMIT_MAX_RST;
      user_min_q <= '0;
      user_max_q <= LIMIT_MAX_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_CURVE:    curve_q    <= cfg_data_i[CURVE_BITS-1:0];
        REG_HARD_MIN: hard_min_q <= cfg_data_i;
        REG_HARD_MAX: hard_max_q <= cfg_data_i;
        REG_USER_MIN: user_min_q <= cfg_data_i;
        REG_USER_MAX: user_max_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (curve_q > CURVE_MAX) begin
      curve_cl = CURVE_MAX;
    end else if (curve_q < CURVE_MIN) begin
      curve_cl = CURVE_MIN;
    end else begin
      curve_cl = curve_q;
    end

    // positive side: 1 + 1.5*c, i.e. 96 per step in Q.16
    p_pos = P_W'(P_ONE) + P_W'({curve_cl[CURVE_BITS-2:0], 6'b0})
          + P_W'({curve_cl[CURVE_BITS-2:0], 5'b0});

    // negative side: 1 - round(0.6*|c|) = 1 - floor((192*|c| + 2) / 5)
    mag      = (CURVE_BITS-1)'(-curve_cl);
    div_num  = D_W'({mag, 7'b0}) + D_W'({mag, 6'b0}) + D_W'(2);
    div_prod = div_num * DIV5_MUL;
    p_neg    = P_W'(P_ONE) - P_W'(div_prod[D_W+19:DIV5_SHIFT]);

    // user limits are kept inside the hard limits only when those are ordered
    umin_c = user_min_q;
    umax_c = user_max_q;
    if (hard_min_q <= hard_max_q) begin
      if (user_min_q < hard_min_q) begin
        umin_c = hard_min_q;
      end else if (user_min_q > hard_max_q) begin
        umin_c = hard_max_q;
      end
      if (user_max_q < hard_min_q) begin
        umax_c = hard_min_q;
      end else if (user_max_q > hard_max_q) begin
        umax_c = hard_max_q;
      end
    end

    cfg_d.p    = curve_cl[CURVE_BITS-1] ? p_neg : p_pos;
    cfg_d.umin = umin_c;
    cfg_d.diff = DIFF_W'(umax_c) - DIFF_W'(umin_c);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.p    <= P_W'(P_ONE);
      cfg_q.umin <= '0;
      cfg_q.diff <= DIFF_W'(LIMIT_MAX_RST);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

### sv/cpcm_ctrl.sv
// pipeline valid bits and per-stage load enables; a held result stalls
// only the full stages behind it; uses cpcm_pkg
module cpcm_ctrl (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [cpcm_pkg::NUM_STAGES-1:0] en_o
);
  import cpcm_pkg::*;

  logic [NUM_STAGES-1:0] valid_q;
  logic [NUM_STAGES-1:0] hold;

  // a stage holds when it and every stage after it are full and the result waits
  for (genvar i = 0; i < NUM_STAGES; i++) begin : g_hold
    assign hold[i] = !out_ready_i && (&valid_q[NUM_STAGES-1:i]);
  end

  assign en_o        = ~hold;
  assign in_ready_o  = !hold[0];
  assign out_valid_o = valid_q[NUM_STAGES-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (!hold[0]) begin
        valid_q[0] <= in_valid_i;
      end
      for (int i = 1; i < NUM_STAGES; i++) begin
        if (!hold[i]) begin
          valid_q[i] <= valid_q[i-1];
        end
      end
    end
  end

endmodule

### sv/cpcm_log2.sv
// normalize the controller value and take -log2 of it, one fraction bit
// per squaring stage; uses cpcm_pkg
module cpcm_log2 (
  input  logic                              clk_i,
  input  logic [cpcm_pkg::ST_NL:0]          en_i,
  input  logic [cpcm_pkg::FRAC_BITS-1:0]    controller_value_i,
  output logic [cpcm_pkg::NL_W-1:0]         nl_o,
  output logic                              zero_o
);
  import cpcm_pkg::*;

  logic [M_W-1:0]      top_bit;
  logic [Z_W-1:0]      z_q    [0:LOG_BITS];
  logic [LOG_BITS-1:0] frac_q [0:LOG_BITS];
  logic [EXP_W-1:0]    e_q    [0:LOG_BITS];
  logic                zero_q [0:LOG_BITS];
  logic [NL_W-1:0]     nl_q;
  logic                nl_zero_q;

  always_comb begin
    top_bit = '0;
    for (int b = 0; b < FRAC_BITS; b++) begin
      if (controller_value_i[b]) begin
        top_bit = M_W'(b);
      end
    end
  end

  // stage 0: leading one to bit 31, value in [1, 2) as Q1.31
  always_ff @(posedge clk_i) begin
    if (en_i[ST_NORM]) begin
      z_q[0]    <= {controller_value_i, {(Z_W-FRAC_BITS){1'b0}}}
                   << (M_W'(FRAC_BITS - 1) - top_bit);
      frac_q[0] <= '0;
      e_q[0]    <= EXP_W'(FRAC_BITS) - EXP_W'(top_bit);
      zero_q[0] <= (controller_value_i == '0);
    end
  end

  for (genvar j = 1; j <= LOG_BITS; j++) begin : g_sq
    logic [2*Z_W-1:0] sq;
    logic [Z_W:0]     sq_top;

    assign sq     = z_q[j-1] * z_q[j-1];
    assign sq_top = sq[2*Z_W-1:Z_W-1];

    // square >= 2 gives a one bit and a halving
    always_ff @(posedge clk_i) begin
      if (en_i[ST_NORM + j]) begin
        z_q[j]    <= sq_top[Z_W] ? sq_top[Z_W:1] : sq_top[Z_W-1:0];
        frac_q[j] <= {frac_q[j-1][LOG_BITS-2:0], sq_top[Z_W]};
        e_q[j]    <= e_q[j-1];
        zero_q[j] <= zero_q[j-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[ST_NL]) begin
      nl_q      <= {e_q[LOG_BITS], {LOG_BITS{1'b0}}} - NL_W'(frac_q[LOG_BITS]);
      nl_zero_q <= zero_q[LOG_BITS];
    end
  end

  assign nl_o   = nl_q;
  assign zero_o = nl_zero_q;

endmodule

### sv/cpcm_exp2.sv
// scale -log2 by the exponent and raise 2 to the negated result, one
// coefficient stage per fraction bit, then the integer shift; uses cpcm_pkg
module cpcm_exp2 (
  input  logic                                    clk_i,
  input  logic [cpcm_pkg::ST_SHIFT:cpcm_pkg::ST_N] en_i,
  input  logic [cpcm_pkg::NL_W-1:0]               nl_i,
  input  logic                                    zero_i,
  input  logic [cpcm_pkg::P_W-1:0]                p_i,
  output logic [cpcm_pkg::Y_W-1:0]                y_o
);
  import cpcm_pkg::*;

  logic [NL_W+P_W-1:0] np;
  logic [N_W-1:0]      n_q    [0:LOG_BITS];
  logic [Y_W-1:0]      y_q    [0:LOG_BITS];
  logic                zero_q [0:LOG_BITS];
  logic [K_W-1:0]      k;
  logic [Y_W-1:0]      y_out_q;

  assign np = nl_i * p_i;

  always_ff @(posedge clk_i) begin
    if (en_i[ST_N]) begin
      n_q[0]    <= np[P_FRAC +: N_W];
      y_q[0]    <= Y_W'(1) << Y_FRAC;
      zero_q[0] <= zero_i;
    end
  end

  for (genvar i = 1; i <= LOG_BITS; i++) begin : g_exp
    localparam logic [C_W-1:0] COEF = exp_coef(i);
    logic [Y_W+C_W-1:0] yc;

    assign yc = y_q[i-1] * COEF;

    // fraction bits taken from the most significant down
    always_ff @(posedge clk_i) begin
      if (en_i[ST_N + i]) begin
        y_q[i]    <= n_q[i-1][LOG_BITS-i] ? yc[C_W +: Y_W] : y_q[i-1];
        n_q[i]    <= n_q[i-1];
        zero_q[i] <= zero_q[i-1];
      end
    end
  end

  assign k = n_q[LOG_BITS][N_W-1:LOG_BITS];

  always_ff @(posedge clk_i) begin
    if (en_i[ST_SHIFT]) begin
      if (zero_q[LOG_BITS] || (k >= K_W'(Y_W))) begin
        y_out_q <= '0;
      end else begin
        y_out_q <= y_q[LOG_BITS] >> k;
      end
    end
  end

  assign y_o = y_out_q;

endmodule

### sv/cpcm_map.sv
// map the curved fraction onto the user limits and truncate toward zero;
// uses cpcm_pkg
module cpcm_map (
  input  logic                                       clk_i,
  input  logic [cpcm_pkg::ST_OUT:cpcm_pkg::ST_MUL]   en_i,
  input  logic [cpcm_pkg::Y_W-1:0]                   y_i,
  input  cpcm_pkg::cfg_t                             cfg_i,
  output logic signed [cpcm_pkg::LIMIT_BITS-1:0]     param_value_o
);
  import cpcm_pkg::*;

  logic signed [PROD_W-1:0]     prod_d, prod_q;
  logic signed [SUM_W-1:0]      sum_d, sum_q;
  logic                         round_up;
  logic signed [LIMIT_BITS-1:0] param_d, param_q;

  assign prod_d = $signed({1'b0, y_i}) * cfg_i.diff;

  always_ff @(posedge clk_i) begin
    if (en_i[ST_MUL]) begin
      prod_q <= prod_d;
    end
  end

  assign sum_d = (SUM_W'(cfg_i.umin) <<< Y_FRAC) + SUM_W'(prod_q);

  always_ff @(posedge clk_i) begin
    if (en_i[ST_SUM]) begin
      sum_q <= sum_d;
    end
  end

  // negative sums with a fraction step up by one to truncate toward zero
  assign round_up = sum_q[SUM_W-1] && (|sum_q[Y_FRAC-1:0]);
  assign param_d  = sum_q[Y_FRAC +: LIMIT_BITS] + LIMIT_BITS'(round_up);

  always_ff @(posedge clk_i) begin
    if (en_i[ST_OUT]) begin
      param_q <= param_d;
    end
  end

  assign param_value_o = param_q;

endmodule

### sv/cpcm_checker.sv
// port-level checks for the controller power-curve map, bound to the top
// uses cpcm_pkg and controller_power_curve_map_core_defines.svh
`include "controller_power_curve_map_core_defines.svh"

module cpcm_checker (
  input logic                                   clk_i,
  input logic                                   rst_ni,
  input logic                                   in_ready_o,
  input logic                                   out_valid_o,
  input logic                                   out_ready_i,
  input logic signed [cpcm_pkg::LIMIT_BITS-1:0] param_value_o,
  input logic                                   cfg_ready_o
);
  import cpcm_pkg::*;

  // a result that is not taken stays put
  `CPCM_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(param_value_o), "result changed while stalled")

  // input back-pressure only comes from a waiting result
  `CPCM_ASSERT_ALWAYS(a_stall_source, !in_ready_o |-> (out_valid_o && !out_ready_i), "input stalled without a held result")

  // register writes are never refused
  `CPCM_ASSERT_ALWAYS(a_cfg_ready, cfg_ready_o, "configuration port not ready")

endmodule

bind controller_power_curve_map_core cpcm_checker u_checker (.*);

### verif/tb.sv
// testbench for controller_power_curve_map_core: directed table, then random phases
// predicts each param_value with its own power-curve model or a fixed table value, compares in order
// depends on cpcm_pkg and the core rtl only
`timescale 1ns / 100ps

module tb;
  import cpcm_pkg::*;

  localparam int TIMEOUT_CYCLES = 200000;
  localparam int TAIL_CYCLES    = 60;
  localparam int HOLD_CYCLES    = 300;
  localparam int NUM_PHASES     = 14;
  localparam int PHASE_ITEMS    = 100;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd5;  // first index with no register

  typedef enum logic [1:0] {ROW_WRITE, ROW_ITEM, ROW_KNOWN} row_kind_e;

  typedef struct packed {
    row_kind_e                    kind;
    logic [CFG_IDX_W-1:0]         idx;
    logic [CFG_DATA_W-1:0]        data;   // register data, or controller value
    logic signed [LIMIT_BITS-1:0] want;
  } row_t;

  logic                         clk_i;
  logic                         rst_ni;
  logic                         in_valid;
  logic                         in_ready;
  logic [FRAC_BITS-1:0]         ctrl_value;
  logic                         out_valid;
  logic                         out_ready;
  logic signed [LIMIT_BITS-1:0] param_value;
  logic                         cfg_valid;
  logic                         cfg_ready;
  logic [CFG_IDX_W-1:0]         cfg_index;
  logic [CFG_DATA_W-1:0]        cfg_data;

  // register copies as last written
  logic [CURVE_BITS-1:0] sh_curve;
  logic [LIMIT_BITS-1:0] sh_hard_min;
  logic [LIMIT_BITS-1:0] sh_hard_max;
  logic [LIMIT_BITS-1:0] sh_user_min;
  logic [LIMIT_BITS-1:0] sh_user_max;

  longint unsigned half_root [1:24];  // 2^(-2^-i) in Q0.32
  logic signed [LIMIT_BITS-1:0] pending_param [$];
  logic signed [LIMIT_BITS-1:0] want_param;
  int err_count;
  int cycle_count;
  int hold_left;
  bit hold_req;
  bit hold_done;
  bit steady;

  row_t plan [0:40] = '{
    '{ROW_KNOWN, REG_CURVE,      24'd0,         24'd0},
    '{ROW_KNOWN, REG_CURVE,      24'd32768,     24'd4194303},
    '{ROW_ITEM,  REG_CURVE,      24'd65535,     24'd0},
    '{ROW_ITEM,  REG_CURVE,      24'd1,         24'd0},
    '{ROW_ITEM,  REG_CURVE,      24'h005555,    24'd0},
    '{ROW_ITEM,  REG_CURVE,      24'h00AAAA,    24'd0},
    '{ROW_WRITE, REG_CURVE,      24'h000400,    24'd0},
    '{ROW_ITEM,  REG_CURVE,      24'd1,         24'd0},
    '{ROW_ITEM,  REG_CURVE,      24'd65535,     24'd0},
    '{ROW_ITEM,  REG_CURVE,      24'd12345,     24'd0},
    '{ROW_WRITE, REG_CURVE,      24'hFFFC00,    24'd0},
    '{ROW_ITEM,  REG_CURVE,      24'd1,         24'd0},
    '{ROW_ITEM,  REG_CURVE,      24'd65535,     24'd0},
    '{ROW_ITEM,  REG_CURVE,      24'd300,       24'd0},
    '{ROW_WRITE, REG_CURVE,      24'h000800,    24'd0},
    '{ROW_ITEM,  REG_CURVE,      24'd40000,     24'd0},
    '{ROW_WRITE, REG_CURVE,      24'h0007FF,    24'd0},
    '{ROW_ITEM,  REG_CURVE,      24'd40000,     24'd0},
    '{ROW_WRITE, REG_HARD_MIN,   24'd100,       24'd0},
    '{ROW_WRITE, REG_HARD_MAX,   24'd200,       24'd0},
    '{ROW_KNOWN, REG_CURVE,      24'd0,         24'd100},
    '{ROW_ITEM,  REG_CURVE,      24'd65535,     24'd0},
    '{ROW_WRITE, REG_HARD_MIN,   24'd500,       24'd0},
    '{ROW_ITEM,  REG_CURVE,      24'd50000,     24'd0},
    '{ROW_WRITE, REG_CURVE,      24'd0,         24'd0},
    '{ROW_WRITE, REG_HARD_MIN,   24'h800000,    24'd0},
    '{ROW_WRITE, REG_HARD_MAX,   24'h7FFFFF,    24'd0},
    '{ROW_WRITE, REG_USER_MIN,   24'h800000,    24'd0},
    '{ROW_WRITE, REG_USER_MAX,   24'h7FFFFF,    24'd0},
    '{ROW_KNOWN, REG_CURVE,      24'd0,         24'h800000},
    '{ROW_ITEM,  REG_CURVE,      24'd65535,     24'd0},
    '{ROW_KNOWN, REG_CURVE,      24'd32768,     24'd0},
    '{ROW_WRITE, REG_USER_MIN,   24'h7FFFFF,    24'd0},
    '{ROW_WRITE, REG_USER_MAX,   24'h800000,    24'd0},
    '{ROW_KNOWN, REG_CURVE,      24'd0,         24'h7FFFFF},
    '{ROW_ITEM,  REG_CURVE,      24'd65535,     24'd0},
    '{ROW_WRITE, REG_SPARE,      24'hFFFFFF,    24'd0},
    '{ROW_WRITE, REG_SPARE + 3'd1, 24'h123456,  24'd0},
    '{ROW_WRITE, REG_SPARE + 3'd2, 24'hFFFFFF,  24'd0},
    '{ROW_KNOWN, REG_CURVE,      24'd0,         24'h7FFFFF},
    '{ROW_ITEM,  REG_CURVE,      24'd20000,     24'd0}
  };

  controller_power_curve_map_core i_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid),
    .in_ready_o         (in_ready),
    .controller_value_i (ctrl_value),
    .out_valid_o        (out_valid),
    .out_ready_i        (out_ready),
    .param_value_o      (param_value),
    .cfg_valid_i        (cfg_valid),
    .cfg_ready_o        (cfg_ready),
    .cfg_index_i        (cfg_index),
    .cfg_data_i         (cfg_data)
  );

  always #10 clk_i = ~clk_i;

  function automatic longint unsigned root_floor(input longint unsigned a);
    longint unsigned r;
    longint unsigned t;
    r = 0;
    for (int b = 31; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t * t <= a) r = t;
    end
    return r;
  endfunction

  // user_min + x^p * (user_max - user_min), x^p as 2^(-p * -log2(x))
  function automatic logic signed [LIMIT_BITS-1:0] map_param(input logic [FRAC_BITS-1:0] v);
    longint crv, hmin, hmax, umin, umax, expo, nl, n, k, f, y, s;
    longint unsigned z, frac;
    int m;
    crv  = longint'($signed(sh_curve));
    hmin = longint'($signed(sh_hard_min));
    hmax = longint'($signed(sh_hard_max));
    umin = longint'($signed(sh_user_min));
    umax = longint'($signed(sh_user_max));
    if (crv > 1024) crv = 1024;
    else if (crv < -1024) crv = -1024;
    // hard limits only bound the user limits when they are in order
    if (hmin <= hmax) begin
      if (umin < hmin) umin = hmin;
      else if (umin > hmax) umin = hmax;
      if (umax < hmin) umax = hmin;
      else if (umax > hmax) umax = hmax;
    end
    if (crv >= 0) expo = 65536 + 96 * crv;
    else expo = 65536 - (192 * (-crv) + 2) / 5;
    y = 0;
    if (v != 0) begin
      m = FRAC_BITS - 1;
      while (!v[m]) m--;
      z = 64'(v);
      z = z << (31 - m);
      frac = 0;
      repeat (LOG_BITS) begin
        z = (z * z) >> 31;
        frac = frac << 1;
        if (z >= 64'h1_0000_0000) begin
          frac = frac | 64'd1;
          z = z >> 1;
        end
      end
      nl = (longint'(FRAC_BITS - m) << 24) - longint'(frac);
      n = (nl * expo) >> 16;
      k = n >> 24;
      f = n & 64'hFF_FFFF;
      y = 64'sd1 << 30;
      for (int i = 1; i <= 24; i++) begin
        if (f[24 - i]) y = (y * half_root[i]) >> 32;
      end
      if (k >= 31) y = 0;
      else y = y >> k;
    end
    s = umin * 1073741824 + y * (umax - umin);
    s = s / 1073741824;
    return s[LIMIT_BITS-1:0];
  endfunction

  task automatic flag_mismatch(input string what, input logic signed [LIMIT_BITS-1:0] got,
                               input logic signed [LIMIT_BITS-1:0] want);
    $display("mismatch at cycle %0d: %s, got %0d want %0d", cycle_count, what, got, want);
    err_count++;
  endtask

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_item(input logic [FRAC_BITS-1:0] v,
                           input logic signed [LIMIT_BITS-1:0] want);
    if (!steady) begin
      while ($urandom_range(0, 99) < 26) begin
        in_valid <= 1'b0;
        @(negedge clk_i);
      end
    end
    in_valid   <= 1'b1;
    ctrl_value <= v;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    pending_param.push_back(want);
    @(negedge clk_i);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    case (idx)
      REG_CURVE:    sh_curve    = data[CURVE_BITS-1:0];
      REG_HARD_MIN: sh_hard_min = data;
      REG_HARD_MAX: sh_hard_max = data;
      REG_USER_MIN: sh_user_min = data;
      REG_USER_MAX: sh_user_max = data;
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  // every item gives one result, so an empty queue means an empty pipeline
  task automatic drain_items;
    in_valid <= 1'b0;
    while (pending_param.size() != 0) @(negedge clk_i);
  endtask

  task automatic set_phase_limits;
    logic [LIMIT_BITS-1:0] a;
    logic [LIMIT_BITS-1:0] b;
    case ($urandom_range(0, 4))
      0: cfg_write(REG_CURVE, 24'hFFFC00);
      1: cfg_write(REG_CURVE, 24'h000400);
      2: cfg_write(REG_CURVE, 24'h000000);
      3: cfg_write(REG_CURVE, $urandom_range(0, 1) ? 24'h000800 : 24'h0007FF);
      default: cfg_write(REG_CURVE, CFG_DATA_W'($urandom_range(0, 24'hFFFFFF)));
    endcase
    a = LIMIT_BITS'($urandom_range(0, 24'hFFFFFF));
    b = LIMIT_BITS'($urandom_range(0, 24'hFFFFFF));
    case ($urandom_range(0, 3))
      0: begin
        cfg_write(REG_HARD_MIN, 24'h800000);
        cfg_write(REG_HARD_MAX, 24'h7FFFFF);
      end
      1: begin
        cfg_write(REG_HARD_MIN, a);
        cfg_write(REG_HARD_MAX, b);
      end
      2: begin
        // out of order: user limits pass through untouched
        cfg_write(REG_HARD_MIN, ($signed(a) > $signed(b)) ? a : b);
        cfg_write(REG_HARD_MAX, ($signed(a) > $signed(b)) ? b : a);
      end
      default: begin
        cfg_write(REG_HARD_MIN, CFG_DATA_W'(-$urandom_range(0, 5000)));
        cfg_write(REG_HARD_MAX, CFG_DATA_W'($urandom_range(0, 5000)));
      end
    endcase
    a = LIMIT_BITS'($urandom_range(0, 24'hFFFFFF));
    b = LIMIT_BITS'($urandom_range(0, 24'hFFFFFF));
    case ($urandom_range(0, 3))
      0: begin
        cfg_write(REG_USER_MIN, 24'h800000);
        cfg_write(REG_USER_MAX, 24'h7FFFFF);
      end
      1: begin
        cfg_write(REG_USER_MIN, 24'h7FFFFF);
        cfg_write(REG_USER_MAX, 24'h800000);
      end
      2: begin
        cfg_write(REG_USER_MIN, a);
        cfg_write(REG_USER_MAX, b);
      end
      default: begin
        cfg_write(REG_USER_MIN, a);
        cfg_write(REG_USER_MAX, a);
      end
    endcase
    if ($urandom_range(0, 3) == 0) cfg_write(CFG_IDX_W'($urandom_range(REG_SPARE, 7)), b);
  endtask

  // result checker
  always @(posedge clk_i) begin
    if (rst_ni && out_valid && out_ready) begin
      if (pending_param.size() == 0) begin
        flag_mismatch("result with nothing pending", param_value, '0);
      end else begin
        want_param = pending_param.pop_front();
        if (param_value !== want_param) flag_mismatch("param_value", param_value, want_param);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= TIMEOUT_CYCLES) begin
      $display("timeout with %0d results pending", pending_param.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  // receiver: random stalls outside the steady phase, one long hold-off so the pipeline backs up
  always @(negedge clk_i) begin
    if (hold_req && !hold_done) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (steady) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= 26);
    end
  end

  initial begin : stim
    longint unsigned cc;
    logic [FRAC_BITS-1:0] v;
    int pick;
    clk_i       = 1'b0;
    rst_ni      = 1'b0;
    in_valid    = 1'b0;
    ctrl_value  = '0;
    out_ready   = 1'b0;
    cfg_valid   = 1'b0;
    cfg_index   = REG_CURVE;
    cfg_data    = '0;
    sh_curve    = '0;
    sh_hard_min = '0;
    sh_hard_max = LIMIT_MAX_RST;
    sh_user_min = '0;
    sh_user_max = LIMIT_MAX_RST;
    cc = 64'h8000_0000;
    for (int i = 1; i <= 24; i++) begin
      cc = root_floor(cc << 32);
      half_root[i] = cc;
    end
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (plan[r]) begin
      case (plan[r].kind)
        ROW_WRITE: begin
          drain_items;
          cfg_write(plan[r].idx, plan[r].data);
        end
        ROW_KNOWN: begin
          cfg_valid <= 1'b0;
          send_item(plan[r].data[FRAC_BITS-1:0], plan[r].want);
        end
        default: begin
          cfg_valid <= 1'b0;
          send_item(plan[r].data[FRAC_BITS-1:0], map_param(plan[r].data[FRAC_BITS-1:0]));
        end
      endcase
    end

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      drain_items;
      set_phase_limits;
      cfg_valid <= 1'b0;
      steady = (ph == 7);
      for (int j = 0; j < PHASE_ITEMS; j++) begin
        if (ph == 2 && j == 20) hold_req = 1'b1;
        pick = $urandom_range(0, 99);
        if (pick < 5) v = '0;
        else if (pick < 20) v = FRAC_BITS'($urandom_range(1, 255));
        else if (pick < 30) v = 16'hFFFF - FRAC_BITS'($urandom_range(0, 255));
        else v = FRAC_BITS'($urandom_range(0, 16'hFFFF));
        send_item(v, map_param(v));
      end
    end

    drain_items;
    repeat (TAIL_CYCLES) @(negedge clk_i);
    if (err_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
